[hw/rtl/dgptb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgptb_pkg
// Shared types, constants and helpers for the distance gated point trail
// buffer: store geometry, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dgptb_pkg;

   // store geometry
   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COORD_W = 32;
   localparam int POINT_W = 3 * COORD_W;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int SEQ_W   = 6;

   // threshold after reset: 0.01 in Q32.32
   localparam logic [SQ_W-1:0] THRESH_RESET = 64'd42949673;

   // input command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      RSP_ACCEPT = 2'd0,
      RSP_DROP   = 2'd1,
      RSP_POINT  = 2'd2,
      RSP_EMPTY  = 2'd3
   } rsp_status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_CMP,
      ST_REC_OUT,
      ST_EMPTY_OUT,
      ST_READ_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture_rec;
      logic capture_read;
      logic do_diff;
      logic do_square;
      logic do_sum;
      logic do_cmp;
      logic load_rec;
      logic load_empty;
      logic load_point;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic seen_first;
      logic count_lt2;
      logic count_eq2;
      logic out_free;
      logic final_point;
   } dp_stat_type;

   // ring pointer step forward, wraps at the store depth
   function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      if (p == ADDR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ADDR_W'(1);
      end
      return r;
   endfunction

   // ring pointer step back, wraps at the store depth
   function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      if (p == '0) begin
         r = ADDR_W'(DEPTH - 1);
      end else begin
         r = p - ADDR_W'(1);
      end
      return r;
   endfunction

endpackage

[hw/rtl/distance_gated_point_trail_buffer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_gated_point_trail_buffer_unit
// Ring store of 3D points that drops a new point lying closer than a
// threshold to the newest stored one, and reads the trail out oldest first.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | command, pos_x, pos_y, pos_z
//   rsp_    | out       | rsp_valid/rsp_stall | status, out_x/y/z, seq, last
//   csr_    | in        | csr_valid/csr_ready | min_distance_squared
//
// A record passes through store read, difference, square, two saturating adds
// with compare and result load before the next request is taken. The very
// first point skips the distance check and goes straight to the result load.
// A readout streams one trail point per cycle while rsp_stall does not hold
// the result register, fed by the single registered read port of the point
// store; under two counted points it gives an empty-trail marker, at two none.
// Reset clears pointers, count and result valid, and loads the threshold with
// 0.01; the store is not cleared. rsp_stall holds the result register and the
// controller waits on it; requests are taken only while the controller idles.
// ----------------------------------------------------------------------------
module distance_gated_point_trail_buffer_unit import dgptb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [SEQ_W-1:0]          rsp_sequence_res,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SQ_W-1:0]           csr_min_distance_squared
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller
   dgptb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   // datapath
   dgptb_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .stat                     (stat),
      .req_pos_x                (req_pos_x),
      .req_pos_y                (req_pos_y),
      .req_pos_z                (req_pos_z),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_min_distance_squared (csr_min_distance_squared),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_out_x                (rsp_out_x),
      .rsp_out_y                (rsp_out_y),
      .rsp_out_z                (rsp_out_z),
      .rsp_sequence_res         (rsp_sequence_res),
      .rsp_last                 (rsp_last)
   );

`ifndef SYNTH
   // only one result register load per cycle
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_rec, cmd.load_empty, cmd.load_point}))
      else $error("more than one result load in a cycle");

   // trail points stream only with more than two counted points
   a_point_count: assert property (@(posedge clock) disable iff (reset)
      cmd.load_point |-> (!stat.count_lt2 && !stat.count_eq2))
      else $error("trail point streamed with too few points");

   // the final trail point returns the controller to idle
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_point && stat.final_point) |=> !req_stall)
      else $error("controller busy after the final trail point");

   // a record or empty result ends the request
   a_single_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rec || cmd.load_empty) |=> !req_stall)
      else $error("controller busy after a single result");
`endif

endmodule

[hw/rtl/dgptb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgptb_ctrl
// Controller state machine: takes one request at a time, sequences the
// distance check for a record and the point stream for a readout.
// ----------------------------------------------------------------------------
module dgptb_ctrl import dgptb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_RECORD) begin
                  state_in = stat.seen_first ? ST_DIFF : ST_REC_OUT;
               end else if (stat.count_lt2) begin
                  state_in = ST_EMPTY_OUT;
               end else if (stat.count_eq2) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ_OUT;
               end
            end
         end
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_CMP;
         ST_CMP:    state_in = ST_REC_OUT;
         ST_REC_OUT, ST_EMPTY_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_OUT: begin
            if (stat.out_free && stat.final_point) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            cmd.capture_rec  = req_valid && (req_command == CMD_RECORD);
            cmd.capture_read = req_valid && (req_command == CMD_READ);
         end
         ST_DIFF:      cmd.do_diff    = 1'b1;
         ST_SQUARE:    cmd.do_square  = 1'b1;
         ST_SUM:       cmd.do_sum     = 1'b1;
         ST_CMP:       cmd.do_cmp     = 1'b1;
         ST_REC_OUT:   cmd.load_rec   = stat.out_free;
         ST_EMPTY_OUT: cmd.load_empty = stat.out_free;
         ST_READ_OUT:  cmd.load_point = stat.out_free;
         default:      cmd            = '0;
      endcase
   end

endmodule

[hw/rtl/dgptb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgptb_datapath
// Point store, ring pointers, threshold register, distance pipeline
// (difference, square, saturating sum, compare) and the result register.
// ----------------------------------------------------------------------------
module dgptb_datapath import dgptb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_stat_type               stat,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SQ_W-1:0]           csr_min_distance_squared,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [SEQ_W-1:0]          rsp_sequence_res,
   output logic                      rsp_last
);

   // magnitude of the difference of two signed words
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] ua;
      logic [COORD_W-1:0] ub;
      ua = {~a[COORD_W-1], a[COORD_W-2:0]};
      ub = {~b[COORD_W-1], b[COORD_W-2:0]};
      return (ua >= ub) ? (ua - ub) : (ub - ua);
   endfunction

   // add that sticks at all ones on overflow
   function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                               input logic [SQ_W-1:0] b);
      logic [SQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
   endfunction

   logic [POINT_W-1:0] mem_ff [DEPTH];
   logic [POINT_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]  rd_addr;

   logic [SQ_W-1:0]    thresh_ff;
   logic [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               seen_ff, seen_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [SEQ_W-1:0]   last_seq_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0]    sum_ff;
   logic               too_close_ff;
   logic               out_free;
   logic               keep_point;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_status_type     rsp_status_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [SEQ_W-1:0]   rsp_seq_ff;
   logic               rsp_last_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign keep_point = cmd.load_rec && !too_close_ff;
   assign csr_ready  = 1'b1;

   // status back to the controller
   always_comb begin
      stat.seen_first  = seen_ff;
      stat.count_lt2   = count_ff < CNT_W'(2);
      stat.count_eq2   = count_ff == CNT_W'(2);
      stat.out_free    = out_free;
      stat.final_point = seq_ff == last_seq_ff;
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_min_distance_squared;
      end
   end

   // readout cursor
   always_comb begin
      idx_in = idx_ff;
      seq_in = seq_ff;
      if (cmd.capture_read) begin
         idx_in = tail_ff;
         seq_in = '0;
      end else if (cmd.load_point) begin
         idx_in = ptr_inc(idx_ff);
         seq_in = seq_ff + SEQ_W'(1);
      end
   end

   // read address: newest point for a record, else the readout cursor
   always_comb begin
      if (cmd.capture_rec) begin
         rd_addr = ptr_dec(head_ff);
      end else begin
         rd_addr = idx_in;
      end
   end

   // point store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (keep_point) begin
         mem_ff[head_ff] <= {pos_x_ff, pos_y_ff, pos_z_ff};
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   // ring pointers and fill count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      if (keep_point) begin
         head_in = ptr_inc(head_ff);
         seen_in = 1'b1;
         if (ptr_inc(head_ff) == tail_ff) begin
            tail_in = ptr_inc(tail_ff);
         end
         if (seen_ff && (count_ff < CNT_W'(DEPTH))) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   // readout cursor registers, last index is count minus three
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      seq_ff <= seq_in;
      if (cmd.capture_read) begin
         last_seq_ff <= SEQ_W'(count_ff - CNT_W'(3));
      end
   end

   // input point capture
   always_ff @(posedge clock) begin
      if (cmd.capture_rec) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
   end

   // distance pipeline: difference, square, partial sum, final sum and compare
   always_ff @(posedge clock) begin
      if (cmd.do_diff) begin
         dx_ff <= abs_diff(rdata_ff[3*COORD_W-1:2*COORD_W], pos_x_ff);
         dy_ff <= abs_diff(rdata_ff[2*COORD_W-1:COORD_W], pos_y_ff);
         dz_ff <= abs_diff(rdata_ff[COORD_W-1:0], pos_z_ff);
      end
      if (cmd.do_square) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
         sqz_ff <= dz_ff * dz_ff;
      end
      if (cmd.do_sum) begin
         sum_ff <= sat_add(sqx_ff, sqy_ff);
      end
      if (cmd.capture_rec) begin
         too_close_ff <= 1'b0;
      end else if (cmd.do_cmp) begin
         too_close_ff <= sat_add(sum_ff, sqz_ff) < thresh_ff;
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rec || cmd.load_empty || cmd.load_point) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.load_rec || cmd.load_empty) begin
         rsp_status_ff <= cmd.load_empty ? RSP_EMPTY :
                          (too_close_ff ? RSP_DROP : RSP_ACCEPT);
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_z_ff      <= '0;
         rsp_seq_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.load_point) begin
         rsp_status_ff <= RSP_POINT;
         rsp_x_ff      <= rdata_ff[3*COORD_W-1:2*COORD_W];
         rsp_y_ff      <= rdata_ff[2*COORD_W-1:COORD_W];
         rsp_z_ff      <= rdata_ff[COORD_W-1:0];
         rsp_seq_ff    <= seq_ff;
         rsp_last_ff   <= seq_ff == last_seq_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_out_z        = rsp_z_ff;
   assign rsp_sequence_res = rsp_seq_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[test/trail_buffer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trail_buffer_checker
// Watches the request, result and threshold channels of the point trail
// buffer, keeps its own copy of the ring store, pointers, count and
// threshold, works out the results each request must cause and compares
// every result transfer, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module trail_buffer_checker import dgptb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_status,
   input  logic signed [COORD_W-1:0] rsp_out_x,
   input  logic signed [COORD_W-1:0] rsp_out_y,
   input  logic signed [COORD_W-1:0] rsp_out_z,
   input  logic [SEQ_W-1:0]          rsp_sequence_res,
   input  logic                      rsp_last,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [SQ_W-1:0]           csr_min_distance_squared,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      rsp_status_type     status;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [SEQ_W-1:0]   seq;
      logic               last;
   } trail_rsp_type;

   // shadow of the block's state
   logic [COORD_W-1:0] trail_x [DEPTH];
   logic [COORD_W-1:0] trail_y [DEPTH];
   logic [COORD_W-1:0] trail_z [DEPTH];
   int                 head_idx;
   int                 tail_idx;
   int                 counted;
   logic               first_seen;
   logic [SQ_W-1:0]    gate_threshold;

   trail_rsp_type      due_rsp [$];
   trail_rsp_type      oldest;
   int                 mismatch_count = 0;
   int                 due_count = 0;

   assign fail_count    = mismatch_count;
   assign pending_count = due_count;

   // exact square of one axis difference, Q32.32
   function automatic logic [SQ_W-1:0] axis_square(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
      logic [COORD_W:0]   diff;
      logic [COORD_W-1:0] mag;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      return SQ_W'(mag) * SQ_W'(mag);
   endfunction

   task automatic compare_field(input string field, input logic [COORD_W-1:0] want,
                                input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // results due for one accepted request, state updated as the block does
   task automatic predict_trail(input logic cmd, input logic [COORD_W-1:0] px,
                                input logic [COORD_W-1:0] py,
                                input logic [COORD_W-1:0] pz);
      int               prev;
      int               idx;
      logic [SQ_W+1:0]  total;
      logic [SQ_W-1:0]  gap_sq;
      logic             dropped;
      trail_rsp_type    r;
      r = '0;
      r.last = 1'b1;
      if (cmd == CMD_RECORD) begin
         dropped = 1'b0;
         if (first_seen) begin
            prev  = (head_idx + DEPTH - 1) % DEPTH;
            total = (SQ_W+2)'(axis_square(trail_x[prev], px))
                  + (SQ_W+2)'(axis_square(trail_y[prev], py))
                  + (SQ_W+2)'(axis_square(trail_z[prev], pz));
            // saturate the sum at the 64-bit maximum
            gap_sq  = (total[SQ_W+1:SQ_W] != 2'b00) ? '1 : total[SQ_W-1:0];
            dropped = (gap_sq < gate_threshold);
            if (!dropped && counted < DEPTH) counted++;
         end
         if (dropped) begin
            r.status = RSP_DROP;
         end else begin
            trail_x[head_idx] = px;
            trail_y[head_idx] = py;
            trail_z[head_idx] = pz;
            head_idx = (head_idx + 1) % DEPTH;
            if (head_idx == tail_idx) tail_idx = (tail_idx + 1) % DEPTH;
            first_seen = 1'b1;
            r.status = RSP_ACCEPT;
         end
         due_rsp = {due_rsp, r};
      end else if (counted < 2) begin
         r.status = RSP_EMPTY;
         due_rsp = {due_rsp, r};
      end else begin
         // two counted points give no readout at all
         idx = tail_idx;
         for (int k = 0; k < counted - 2; k++) begin
            r.status = RSP_POINT;
            r.x      = trail_x[idx];
            r.y      = trail_y[idx];
            r.z      = trail_z[idx];
            r.seq    = SEQ_W'(k);
            r.last   = (k == counted - 3);
            due_rsp = {due_rsp, r};
            idx = (idx + 1) % DEPTH;
         end
      end
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         head_idx       = 0;
         tail_idx       = 0;
         counted        = 0;
         first_seen     = 1'b0;
         gate_threshold = THRESH_RESET;
         due_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               $error("result transfer with none due: status %0d seq %0d",
                      rsp_status, rsp_sequence_res);
               mismatch_count++;
            end else begin
               oldest = due_rsp.pop_front();
               compare_field("status", COORD_W'(oldest.status), COORD_W'(rsp_status));
               compare_field("out_x", oldest.x, rsp_out_x);
               compare_field("out_y", oldest.y, rsp_out_y);
               compare_field("out_z", oldest.z, rsp_out_z);
               compare_field("sequence_res", COORD_W'(oldest.seq),
                             COORD_W'(rsp_sequence_res));
               compare_field("last", COORD_W'(oldest.last), COORD_W'(rsp_last));
            end
         end
         if (csr_valid && csr_ready) gate_threshold = csr_min_distance_squared;
         if (req_valid && !req_stall)
            predict_trail(req_command, req_pos_x, req_pos_y, req_pos_z);
      end
      due_count = due_rsp.size();
   end

endmodule

[test/distance_gated_point_trail_buffer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_gated_point_trail_buffer_unit_tb
// Drives record and readout requests into the point trail buffer: a directed
// opening over empty and short trails, exact threshold hits and saturated
// distances, then random phases under several thresholds with bursty gaps on
// both channels and one long result hold. A checker beside the block does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module distance_gated_point_trail_buffer_unit_tb;
   import dgptb_pkg::*;

   localparam int                 LONG_HOLD     = 200;
   localparam int                 SETTLE_CYCLES = 12;
   localparam int                 TAIL_CYCLES   = 80;
   localparam logic [COORD_W-1:0] COORD_MIN     = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX     = 32'h7FFF_FFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_RECORD;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [SEQ_W-1:0]          rsp_sequence_res;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [SQ_W-1:0]           csr_min_distance_squared = '0;

   int                        fail_count;
   int                        pending_count;
   int                        idle_pct = 0;
   bit                        hold_pending = 1'b0;
   logic [COORD_W-1:0]        last_x = '0;
   logic [COORD_W-1:0]        last_y = '0;
   logic [COORD_W-1:0]        last_z = '0;

   distance_gated_point_trail_buffer_unit DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_command              (req_command),
      .req_pos_x                (req_pos_x),
      .req_pos_y                (req_pos_y),
      .req_pos_z                (req_pos_z),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_out_x                (rsp_out_x),
      .rsp_out_y                (rsp_out_y),
      .rsp_out_z                (rsp_out_z),
      .rsp_sequence_res         (rsp_sequence_res),
      .rsp_last                 (rsp_last),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_min_distance_squared (csr_min_distance_squared)
   );

   trail_buffer_checker u_checker (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_command              (req_command),
      .req_pos_x                (req_pos_x),
      .req_pos_y                (req_pos_y),
      .req_pos_z                (req_pos_z),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_out_x                (rsp_out_x),
      .rsp_out_y                (rsp_out_y),
      .rsp_out_z                (rsp_out_z),
      .rsp_sequence_res         (rsp_sequence_res),
      .rsp_last                 (rsp_last),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_min_distance_squared (csr_min_distance_squared),
      .fail_count               (fail_count),
      .pending_count            (pending_count)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall bursts, plus one long hold on request
   initial begin
      int burst;
      int hold;
      burst = 0;
      hold  = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold = LONG_HOLD;
            hold_pending = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request transfer, with an optional gap in front
   task automatic send_item(input logic cmd, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_pos_x   <= x;
      req_pos_y   <= y;
      req_pos_z   <= z;
      if (cmd == CMD_RECORD) begin
         last_x = x;
         last_y = y;
         last_z = z;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering, let every due result arrive and the block go idle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [SQ_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid                <= 1'b1;
      csr_min_distance_squared <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random mix of readouts and records near, around or far from the last point
   task automatic run_phase(input int count, input int read_pct, input int spread);
      int mode;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < read_pct) begin
            send_item(CMD_READ, $urandom, $urandom, $urandom);
         end else begin
            mode = $urandom_range(99);
            if (mode < 5) begin
               send_item(CMD_RECORD, last_x, last_y, last_z);
            end else if (mode < 60) begin
               send_item(CMD_RECORD,
                         last_x + COORD_W'(int'($urandom_range(2 * spread)) - spread),
                         last_y + COORD_W'(int'($urandom_range(2 * spread)) - spread),
                         last_z + COORD_W'(int'($urandom_range(2 * spread)) - spread));
            end else if (mode < 85) begin
               send_item(CMD_RECORD,
                         last_x + COORD_W'(int'($urandom_range(1 << 21)) - (1 << 20)),
                         last_y + COORD_W'(int'($urandom_range(1 << 21)) - (1 << 20)),
                         last_z + COORD_W'(int'($urandom_range(1 << 21)) - (1 << 20)));
            end else begin
               send_item(CMD_RECORD, $urandom, $urandom, $urandom);
            end
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty trail, first point, zero distance, saturated distances
      idle_pct = 0;
      send_item(CMD_READ, COORD_MAX, COORD_MIN, '1);
      send_item(CMD_RECORD, COORD_MIN, COORD_MAX, '0);
      send_item(CMD_READ, '0, '0, '0);
      send_item(CMD_RECORD, COORD_MIN, COORD_MAX, '0);
      send_item(CMD_RECORD, COORD_MAX, COORD_MIN, '1);
      send_item(CMD_READ, '0, '0, '0);
      send_item(CMD_RECORD, COORD_MIN, COORD_MIN, COORD_MIN);
      // two counted points: readout with no result
      send_item(CMD_READ, '0, '0, '0);
      // just under and just over the reset threshold
      send_item(CMD_RECORD, COORD_MIN + 6553, COORD_MIN, COORD_MIN);
      send_item(CMD_RECORD, COORD_MIN + 6554, COORD_MIN, COORD_MIN);
      send_item(CMD_READ, '0, '0, '0);

      // threshold at its maximum: only a saturated sum gets through
      write_threshold('1);
      send_item(CMD_RECORD, COORD_MAX, COORD_MAX, COORD_MAX);
      send_item(CMD_RECORD, '0, '0, '0);
      send_item(CMD_RECORD, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(CMD_READ, '0, '0, '0);

      // small threshold: distance equal to it is kept, below is dropped
      write_threshold(64'd100);
      send_item(CMD_RECORD, COORD_MIN + 10, COORD_MIN, COORD_MIN);
      send_item(CMD_RECORD, COORD_MIN + 10, COORD_MIN + 9, COORD_MIN);
      send_item(CMD_READ, '0, '0, '0);

      // random phases
      write_threshold(THRESH_RESET);
      idle_pct = 25;
      run_phase(40, 15, 8192);

      // nothing dropped: trail fills, wraps and the count saturates
      write_threshold('0);
      idle_pct = 0;
      hold_pending = 1'b1;
      run_phase(80, 10, 1 << 20);

      write_threshold({24'd0, 8'($urandom_range(255)), 32'($urandom)});
      idle_pct = 30;
      run_phase(40, 15, 1 << 19);

      write_threshold(64'h0000_0001_0000_0000);
      idle_pct = 25;
      run_phase(40, 15, 1 << 16);

      write_threshold('1);
      idle_pct = 20;
      run_phase(30, 15, 1 << 20);

      // closing stretch without gaps
      write_threshold(THRESH_RESET);
      idle_pct = 0;
      run_phase(50, 15, 8192);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[distance_gated_point_trail_buffer_unit.f]
hw/rtl/dgptb_pkg.sv
hw/rtl/dgptb_ctrl.sv
hw/rtl/dgptb_datapath.sv
hw/rtl/distance_gated_point_trail_buffer_unit.sv
test/trail_buffer_checker.sv
test/distance_gated_point_trail_buffer_unit_tb.sv
